/* sv/pixel_fade_scaler_defines.svh */
// Assertion macros shared by the pixel fade scaler checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef PIXEL_FADE_SCALER_DEFINES_SVH
`define PIXEL_FADE_SCALER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define PFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define PFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/pfs_pkg.sv */
// Package for the pixel fade scaler: widths, format and register codes,
// and the per-channel scaling function. No dependencies.
`timescale 1ns / 1ps

package pfs_pkg;

	localparam int PIX_W      = 32;
	localparam int FMT_W      = 3;
	localparam int RATE_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int CHAN_W     = 8;

	// floor(x / 100) == (x * 5243) >> 19 for every x below 25600
	localparam int SCALE_W     = 20;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = 28;

	localparam logic [SCALE_W-1:0] FADE_RECIP = 20'd5243;
	localparam logic [RATE_W-1:0]  RATE_FULL  = 7'd100;

	// pixel layouts
	localparam logic [FMT_W-1:0] PF_RGB565 = 3'd0;
	localparam logic [FMT_W-1:0] PF_RGB555 = 3'd1;
	localparam logic [FMT_W-1:0] PF_RGB888 = 3'd2;
	localparam logic [FMT_W-1:0] PF_BGR888 = 3'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_RATE    = 2'd1;

	// scaled = floor(c * rate / 100), with k = rate * FADE_RECIP
	function automatic logic [CHAN_W-1:0] scale_chan(
		input logic [CHAN_W-1:0]  c,
		input logic [SCALE_W-1:0] k
	);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(c) * PROD_W'(k);
		return prod[RECIP_SHIFT +: CHAN_W];
	endfunction

endpackage

/* sv/pixel_fade_scaler.sv */
// Pixel fade scaler top level: input register, channel scaling, output register.
// Depends on pfs_pkg.
`timescale 1ns / 1ps

// Scales each color channel of a pixel word by a fade percentage,
// result = floor(channel * rate / 100), alpha byte kept in 32-bit layouts.
// Channels:
//   s_axis_*  one pixel per beat in, m_axis_* one faded pixel per beat out.
//   cfg_*     register writes: index 0 pixel_format, index 1 fade_rate.
//             Always ready; write only while no pixel is in flight.
// Path: input register, channel scaling, then the output register driving m_axis.
// Throughput: one pixel per cycle while m_axis_tready is high; the single scaling
// stage sits between the input register and the output register.
// Stall: when m_axis_tready is low the output beat holds; an empty input register
// still takes one more beat, then s_axis_tready drops until the output moves.
// Reset: both pipeline stages empty, pixel_format RGB565, fade_rate 100.
// Rates above 100 act as 100; formats 4 to 7 pass the pixel unchanged.
module pixel_fade_scaler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [pfs_pkg::PIX_W-1:0]       s_axis_tdata,  // [31:0] pixel_in
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [pfs_pkg::PIX_W-1:0]       m_axis_tdata,  // [31:0] pixel_out
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [pfs_pkg::FMT_W-1:0]   pixel_format_q;
	logic [pfs_pkg::SCALE_W-1:0] scale_q;
	logic [pfs_pkg::RATE_W-1:0]  rate_eff;
	logic [pfs_pkg::SCALE_W-1:0] scale_next;

	logic                        vld_s1;
	logic [pfs_pkg::PIX_W-1:0]   pixel_s1;
	logic                        vld_s2;
	logic [pfs_pkg::PIX_W-1:0]   pixel_s2;

	logic                        adv_s1;
	logic                        take_in;
	logic [pfs_pkg::CHAN_W-1:0]  ch_r, ch_g, ch_b;
	logic [pfs_pkg::CHAN_W-1:0]  sc_r, sc_g, sc_b;
	logic [pfs_pkg::PIX_W-1:0]   faded;

	assign cfg_ready = 1'b1;

	// clamp and precompute the reciprocal-scaled rate at write time
	assign rate_eff   = (cfg_data > pfs_pkg::RATE_FULL) ? pfs_pkg::RATE_FULL : cfg_data;
	assign scale_next = pfs_pkg::SCALE_W'(rate_eff) * pfs_pkg::FADE_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= pfs_pkg::PF_RGB565;
			scale_q        <= pfs_pkg::SCALE_W'(pfs_pkg::RATE_FULL) * pfs_pkg::FADE_RECIP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pfs_pkg::REG_PIXEL_FORMAT: begin
					pixel_format_q <= cfg_data[pfs_pkg::FMT_W-1:0];
				end
				pfs_pkg::REG_FADE_RATE: begin
					scale_q <= scale_next;
				end
				default: begin
				end
			endcase
		end
	end

	// stage 1 moves on when the output register is empty or being drained
	assign adv_s1        = !vld_s2 || m_axis_tready;
	assign s_axis_tready = !vld_s1 || adv_s1;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			pixel_s1 <= s_axis_tdata;
		end
		if (adv_s1 && vld_s1) begin
			pixel_s2 <= faded;
		end
	end

	// pick channels by layout, scale once, repack
	always_comb begin
		case (pixel_format_q)
			pfs_pkg::PF_RGB565: begin
				ch_r = pfs_pkg::CHAN_W'(pixel_s1[15:11]);
				ch_g = pfs_pkg::CHAN_W'(pixel_s1[10:5]);
				ch_b = pfs_pkg::CHAN_W'(pixel_s1[4:0]);
			end
			pfs_pkg::PF_RGB555: begin
				ch_r = pfs_pkg::CHAN_W'(pixel_s1[14:10]);
				ch_g = pfs_pkg::CHAN_W'(pixel_s1[9:5]);
				ch_b = pfs_pkg::CHAN_W'(pixel_s1[4:0]);
			end
			default: begin
				ch_r = pixel_s1[23:16];
				ch_g = pixel_s1[15:8];
				ch_b = pixel_s1[7:0];
			end
		endcase
	end

	assign sc_r = pfs_pkg::scale_chan(ch_r, scale_q);
	assign sc_g = pfs_pkg::scale_chan(ch_g, scale_q);
	assign sc_b = pfs_pkg::scale_chan(ch_b, scale_q);

	always_comb begin
		case (pixel_format_q)
			pfs_pkg::PF_RGB565: begin
				faded = {16'h0000, sc_r[4:0], sc_g[5:0], sc_b[4:0]};
			end
			pfs_pkg::PF_RGB555: begin
				faded = {16'h0000, 1'b0, sc_r[4:0], sc_g[4:0], sc_b[4:0]};
			end
			pfs_pkg::PF_RGB888, pfs_pkg::PF_BGR888: begin
				// alpha byte kept as is
				faded = {pixel_s1[31:24], sc_r, sc_g, sc_b};
			end
			default: begin
				faded = pixel_s1;
			end
		endcase
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = pixel_s2;

endmodule

/* sv/pfs_checker.sv */
// Port-level checker for the pixel fade scaler, bound to the top level.
// Depends on pfs_pkg and pixel_fade_scaler_defines.svh.
`timescale 1ns / 1ps
`include "pixel_fade_scaler_defines.svh"

module pfs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [pfs_pkg::PIX_W-1:0]       m_axis_tdata
);

	// a stalled output beat holds its data
	`PFS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

	// an empty output register means the input side has room
	`PFS_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input not ready with empty output")

	// an accepted beat shows as a valid output beat once past the input and output registers
	`PFS_ASSERT_NEXT(a_latency, s_axis_tvalid && s_axis_tready, ##1 m_axis_tvalid, "accepted beat missing at output")

endmodule

bind pixel_fade_scaler pfs_checker u_pfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/pfs_fade_checker.sv */
// Scoreboard for the pixel fade scaler: watches the config, pixel-in and pixel-out
// channels, predicts each faded pixel and compares it. Depends on pfs_pkg.
`timescale 1ns / 1ps

module pfs_fade_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [pfs_pkg::PIX_W-1:0]       s_axis_tdata,  // [31:0] pixel_in
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [pfs_pkg::PIX_W-1:0]       m_axis_tdata,  // [31:0] pixel_out
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              fail_count,
	output int                              outstanding
);
	import pfs_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic [FMT_W-1:0]  fmt_copy  = PF_RGB565;
	logic [RATE_W-1:0] rate_copy = RATE_FULL;
	logic [PIX_W-1:0]  faded_q [$];

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	function automatic int unsigned chan_dim(input logic [CHAN_W-1:0] c,
		input int unsigned pct);
		return (32'(c) * pct) / 32'(RATE_FULL);
	endfunction

	function automatic logic [PIX_W-1:0] faded_pixel(
		input logic [PIX_W-1:0]  p,
		input logic [FMT_W-1:0]  fmt,
		input logic [RATE_W-1:0] rate
	);
		int unsigned pct;
		pct = (rate > RATE_FULL) ? 32'(RATE_FULL) : 32'(rate);
		case (fmt)
			PF_RGB565: return {16'h0000, 5'(chan_dim(CHAN_W'(p[15:11]), pct)),
				6'(chan_dim(CHAN_W'(p[10:5]), pct)),
				5'(chan_dim(CHAN_W'(p[4:0]), pct))};
			// bit 15 is dropped in the 555 layout
			PF_RGB555: return {16'h0000, 1'b0, 5'(chan_dim(CHAN_W'(p[14:10]), pct)),
				5'(chan_dim(CHAN_W'(p[9:5]), pct)),
				5'(chan_dim(CHAN_W'(p[4:0]), pct))};
			// both 32-bit layouts scale the same byte lanes; alpha is kept
			PF_RGB888, PF_BGR888: return {p[31:24], 8'(chan_dim(p[23:16], pct)),
				8'(chan_dim(p[15:8], pct)), 8'(chan_dim(p[7:0], pct))};
			default: return p;
		endcase
	endfunction

	task automatic note_fail(input string what, input logic [PIX_W-1:0] want,
		input logic [PIX_W-1:0] got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		logic [PIX_W-1:0] want;
		if (!arst_n) begin
			fmt_copy  = PF_RGB565;
			rate_copy = RATE_FULL;
			faded_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_PIXEL_FORMAT)
					fmt_copy = cfg_data[FMT_W-1:0];
				else if (cfg_index == REG_FADE_RATE)
					rate_copy = cfg_data[RATE_W-1:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				faded_q.push_back(faded_pixel(s_axis_tdata, fmt_copy, rate_copy));
			if (m_axis_tvalid && m_axis_tready) begin
				if (faded_q.size() == 0) begin
					note_fail("pixel_out beat with nothing pending", 'x, m_axis_tdata);
				end else begin
					want = faded_q.pop_front();
					if (m_axis_tdata !== want)
						note_fail("pixel_out mismatch", want, m_axis_tdata);
				end
			end
		end
		outstanding <= faded_q.size();
	end

endmodule

/* tb/sv/tb_pixel_fade_scaler.sv */
// Top of the pixel fade scaler testbench: clock, reset, stimulus, verdict.
// Depends on pfs_pkg, pixel_fade_scaler and pfs_fade_checker.
`timescale 1ns / 1ps

module tb_pixel_fade_scaler;
	import pfs_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 4;
	localparam int RANDOM_PIXELS = 1500;
	localparam int DIR_PHASES    = 7;

	localparam logic [FMT_W-1:0]     PF_OTHER     = 3'd4;
	localparam logic [FMT_W-1:0]     PF_OTHER_TOP = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3  = 2'd3;

	localparam logic [FMT_W-1:0] DIR_FMT [DIR_PHASES] = '{PF_RGB565, PF_RGB555,
		PF_RGB888, PF_BGR888, PF_OTHER, PF_OTHER_TOP, PF_RGB565};
	localparam logic [RATE_W-1:0] DIR_RATE [DIR_PHASES] = '{7'd100, 7'd0, 7'd50,
		7'd99, 7'd1, 7'd127, 7'd101};
	localparam logic [PIX_W-1:0] DIR_PIX [3] = '{32'hFFFF_FFFF, 32'h0000_0000,
		32'h80FF_7FE0};

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [PIX_W-1:0]      m_axis_tdata;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	int fail_count;
	int outstanding;
	bit src_gaps  = 1'b0;
	bit sink_gaps = 1'b0;
	int sink_hold = 0;

	pixel_fade_scaler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pfs_fade_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	// push bytes toward the channel extremes a good part of the time
	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [PIX_W-1:0] p;
		p = $urandom;
		for (int i = 0; i < PIX_W / 8; i++) begin
			case ($urandom_range(0, 5))
				0: p[i*8 +: 8] = 8'h00;
				1: p[i*8 +: 8] = 8'hFF;
				default: ;
			endcase
		end
		return p;
	endfunction

	function automatic logic [RATE_W-1:0] rand_rate();
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return RATE_FULL;
			2: return 7'($urandom_range(101, 127));
			default: return 7'($urandom_range(1, 99));
		endcase
	endfunction

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (sink_gaps && $urandom_range(0, 3) == 0)
				sink_hold <= gap_len();
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		int gap;
		if (src_gaps && $urandom_range(0, 2) == 0) begin
			gap = gap_len();
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drop valid and wait until every predicted pixel has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data, input bit last_beat);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (last_beat)
			cfg_valid <= 1'b0;
	endtask

	initial begin
		int sent;
		int phase_len;
		logic [FMT_W-1:0] fmt;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first phase runs on the reset settings
		for (int ph = 0; ph < DIR_PHASES; ph++) begin
			if (ph != 0) begin
				write_cfg(REG_PIXEL_FORMAT, CFG_DATA_W'(DIR_FMT[ph]), 1'b0);
				write_cfg(REG_FADE_RATE, CFG_DATA_W'(DIR_RATE[ph]), ph != DIR_PHASES - 1);
				// out-of-range indexes must leave both registers alone
				if (ph == DIR_PHASES - 1) begin
					write_cfg(REG_SPARE_2, '0, 1'b0);
					write_cfg(REG_SPARE_3, '0, 1'b1);
				end
			end
			foreach (DIR_PIX[i])
				send_pixel(DIR_PIX[i]);
			drain();
		end

		// random phases; the first one runs back to back with no stalls
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			fmt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(4, 7))
				: 3'($urandom_range(0, 3));
			write_cfg(REG_PIXEL_FORMAT, {4'($urandom), fmt}, 1'b0);
			write_cfg(REG_FADE_RATE, rand_rate(), 1'b1);
			src_gaps   = (sent != 0) && ($urandom_range(0, 2) != 0);
			sink_gaps <= (sent != 0) && ($urandom_range(0, 2) != 0);
			phase_len  = $urandom_range(60, 180);
			repeat (phase_len)
				send_pixel(rand_pixel());
			sent += phase_len;
			drain();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// end the run if no channel moves a beat for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/pfs_pkg.sv
sv/pixel_fade_scaler.sv
sv/pfs_checker.sv
tb/sv/pfs_fade_checker.sv
tb/sv/tb_pixel_fade_scaler.sv
